>>> hdl/pli_pkg.sv
`default_nettype none

package pli_pkg;

   localparam int DATA_W = 32;   // x, y, slope, intercept and result width
   localparam int DIFF_W = 33;   // exact difference of two data words

   // action codes carried on req_tuser
   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_QUERY = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // status codes carried on rsp_tuser
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_FEW  = 2'd2;

   localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_SCAN,
      ST_SEG,
      ST_MUL,
      ST_ADD,
      ST_PUSH
   } state_type;

   // one segment record as stored in the segment RAM
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] slope;
      logic signed [DATA_W-1:0] icpt;
   } seg_entry_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // clamp a 65-bit signed sum to 32 bits signed
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [64:0] v);
      logic signed [DATA_W-1:0] r;
      if (!v[64] && (|v[63:31])) begin
         r = SAT_MAX;
      end else if (v[64] && !(&v[63:31])) begin
         r = SAT_MIN;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/pli_ram.sv
`default_nettype none

module pli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/pli_divider.sv
`default_nettype none

// Unsigned restoring divider, one quotient bit per cycle.
module pli_divider #(
   parameter int NUM_W = 57,
   parameter int DEN_W = 33
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [NUM_W-1:0]      dividend,
   input  logic [DEN_W-1:0]      divisor,
   output logic [NUM_W-1:0]      quotient,
   output pli_pkg::div_stat_type stat
);

   import pli_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [NUM_W-1:0] quo_ff;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;
   logic [DEN_W-1:0] rem_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[NUM_W-1]};
      diff   = trial - {1'b0, den_ff};
      ge     = (trial >= {1'b0, den_ff});
      rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

>>> hdl/piecewise_linear_interpolator.sv
// Load: START, DIV (bit-serial slope divider, 33 + FRAC_BITS quotient bits, one per cycle),
//   MUL, ADD, PUSH; first point, repeated x or full table: START, PUSH.
// Query: START, SCAN, SEG, MUL, ADD, PUSH; the breakpoint scan reads one RAM entry a cycle.
// SCAN/SEG exit to PUSH if no segment fits. Clear, too-few-points, unused action: START, PUSH.
// One item at a time; the next beat is taken once the result sits in the output register.
// Reset (sync, active high) clears point count, last point and control; RAMs are not cleared.
`default_nettype none

module piecewise_linear_interpolator #(
   parameter int TABLE_DEPTH = 256,
   parameter int FRAC_BITS   = 24
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // [31:0] point_x, [63:32] point_y, [95:64] query_point
   input  logic [1:0]  req_tuser,   // [1:0] action
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   import pli_pkg::*;

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CW    = $clog2(TABLE_DEPTH + 1);
   localparam int NUM_W = DIFF_W + FRAC_BITS;
   localparam int SEG_W = $bits(seg_entry_type);

   localparam logic [NUM_W-1:0] QNEG_LIM = NUM_W'(64'h8000_0000);
   localparam logic [NUM_W-1:0] QPOS_LIM = NUM_W'(64'h7FFF_FFFF);

   // ---------------------------------------------------------------
   // state
   // ---------------------------------------------------------------
   state_type state_ff, state_in;

   logic [CW-1:0]            count_ff;      // stored breakpoints
   logic signed [DATA_W-1:0] last_x_ff;
   logic signed [DATA_W-1:0] last_y_ff;
   logic                     rsp_tvalid_ff;

   // captured request beat
   logic [1:0]               act_ff;
   logic signed [DATA_W-1:0] x_ff;
   logic signed [DATA_W-1:0] y_ff;
   logic signed [DATA_W-1:0] q_ff;

   // working registers
   logic [AW-1:0]            chk_ff;        // segment whose right breakpoint is on the read port
   logic [AW-1:0]            seg_idx_ff;    // segment being fetched for a query
   logic [AW-1:0]            seg_addr_ff;   // segment being closed by a load
   logic                     fallback_ff;   // already stepped back one segment
   logic                     neg_ff;        // slope sign
   logic signed [DATA_W-1:0] slope_ff;
   logic signed [DATA_W-1:0] icpt_ff;
   logic signed [63:0]       prod_ff;
   logic signed [DATA_W-1:0] res_value_ff;
   logic [1:0]               res_status_ff;
   logic [DATA_W-1:0]        rsp_tdata_ff;
   logic [1:0]               rsp_tuser_ff;

   // ---------------------------------------------------------------
   // memories
   // ---------------------------------------------------------------
   logic                bp_wr_en;
   logic                bp_rd_en;
   logic [AW-1:0]       bp_rd_addr;
   logic [DATA_W-1:0]   bp_rd_data;
   logic                seg_wr_en;
   logic [AW-1:0]       seg_wr_addr;
   seg_entry_type       seg_wr_data;
   logic                seg_rd_en;
   logic [AW-1:0]       seg_rd_addr;
   logic [SEG_W-1:0]    seg_rd_raw;
   seg_entry_type       seg_rd;

   pli_ram #(
      .WIDTH (DATA_W),
      .DEPTH (TABLE_DEPTH)
   ) u_bp_ram (
      .clock   (clock),
      .wr_en   (bp_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (x_ff),
      .rd_en   (bp_rd_en),
      .rd_addr (bp_rd_addr),
      .rd_data (bp_rd_data)
   );

   pli_ram #(
      .WIDTH (SEG_W),
      .DEPTH (TABLE_DEPTH)
   ) u_seg_ram (
      .clock   (clock),
      .wr_en   (seg_wr_en),
      .wr_addr (seg_wr_addr),
      .wr_data (seg_wr_data),
      .rd_en   (seg_rd_en),
      .rd_addr (seg_rd_addr),
      .rd_data (seg_rd_raw)
   );

   assign seg_rd = seg_rd_raw;

   // ---------------------------------------------------------------
   // slope divider: |dy| * 2^F / |dx|
   // ---------------------------------------------------------------
   logic signed [DIFF_W-1:0] dx;
   logic signed [DIFF_W-1:0] dy;
   logic [DIFF_W-1:0]        dx_mag;
   logic [DIFF_W-1:0]        dy_mag;
   logic                     div_start;
   logic [NUM_W-1:0]         div_quo;
   div_stat_type             div_stat;

   always_comb begin
      dx     = {x_ff[DATA_W-1], x_ff} - {last_x_ff[DATA_W-1], last_x_ff};
      dy     = {y_ff[DATA_W-1], y_ff} - {last_y_ff[DATA_W-1], last_y_ff};
      dx_mag = dx[DIFF_W-1] ? (DIFF_W'(0) - dx) : dx;
      dy_mag = dy[DIFF_W-1] ? (DIFF_W'(0) - dy) : dy;
   end

   pli_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DIFF_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({dy_mag, {FRAC_BITS{1'b0}}}),
      .divisor  (dx_mag),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   // ---------------------------------------------------------------
   // datapath decodes
   // ---------------------------------------------------------------
   logic                     table_full;
   logic                     too_few;
   logic                     scan_hit;
   logic                     scan_last;
   logic                     can_fall_back;
   logic                     out_free;
   logic                     out_load;
   logic signed [DATA_W-1:0] slope_sat;
   logic signed [DATA_W-1:0] mul_b;
   logic signed [63:0]       prod_sh;
   logic signed [64:0]       sum_wide;
   logic signed [DATA_W-1:0] sum_sat;

   always_comb begin
      table_full    = (count_ff == CW'(TABLE_DEPTH));
      too_few       = (count_ff < CW'(2));
      scan_hit      = (q_ff < $signed(bp_rd_data));
      scan_last     = (CW'(chk_ff) == count_ff - CW'(2));
      can_fall_back = !fallback_ff && (seg_idx_ff != '0);
      out_free      = !rsp_tvalid_ff || rsp_tready;

      // truncate toward zero already done by the divider; clamp to 32 bits here
      if (neg_ff) begin
         slope_sat = (div_quo > QNEG_LIM) ? SAT_MIN : $signed(32'd0 - div_quo[DATA_W-1:0]);
      end else begin
         slope_sat = (div_quo > QPOS_LIM) ? SAT_MAX : $signed(div_quo[DATA_W-1:0]);
      end

      mul_b   = (act_ff == ACT_LOAD) ? x_ff : q_ff;
      prod_sh = prod_ff >>> FRAC_BITS;   // floor division by 2^F
      if (act_ff == ACT_LOAD) begin
         // intercept = y - floor(m*x / 2^F)
         sum_wide = $signed({{33{y_ff[DATA_W-1]}}, y_ff}) - $signed({prod_sh[63], prod_sh});
      end else begin
         // value = intercept + floor(m*q / 2^F)
         sum_wide = $signed({{33{icpt_ff[DATA_W-1]}}, icpt_ff}) + $signed({prod_sh[63], prod_sh});
      end
      sum_sat = sat32(sum_wide);
   end

   // ---------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            case (act_ff)
               ACT_LOAD: begin
                  if (!table_full && (count_ff != '0) && (dx != '0)) begin
                     state_in = ST_DIV;
                  end else begin
                     state_in = ST_PUSH;
                  end
               end
               ACT_QUERY: begin
                  state_in = too_few ? ST_PUSH : ST_SCAN;
               end
               default: begin
                  state_in = ST_PUSH;
               end
            endcase
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_MUL;
            end
         end
         ST_SCAN: begin
            if (scan_hit) begin
               state_in = ST_SEG;
            end else if (scan_last) begin
               state_in = ST_PUSH;   // at or beyond the last breakpoint
            end
         end
         ST_SEG: begin
            if (seg_rd.valid) begin
               state_in = ST_MUL;
            end else if (!can_fall_back) begin
               state_in = ST_PUSH;
            end
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // outputs of the sequencer
   // ---------------------------------------------------------------
   always_comb begin
      req_tready  = 1'b0;
      bp_wr_en    = 1'b0;
      bp_rd_en    = 1'b0;
      bp_rd_addr  = '0;
      seg_wr_en   = 1'b0;
      seg_wr_addr = '0;
      seg_wr_data = '0;
      seg_rd_en   = 1'b0;
      seg_rd_addr = '0;
      div_start   = 1'b0;
      out_load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_START: begin
            case (act_ff)
               ACT_LOAD: begin
                  if (!table_full) begin
                     bp_wr_en = 1'b1;
                     if (count_ff != '0) begin
                        if (dx == '0) begin
                           // zero-width segment: stored invalid with zero slope/intercept
                           seg_wr_en   = 1'b1;
                           seg_wr_addr = AW'(count_ff - CW'(1));
                        end else begin
                           div_start = 1'b1;
                        end
                     end
                  end
               end
               ACT_QUERY: begin
                  if (!too_few) begin
                     bp_rd_en   = 1'b1;
                     bp_rd_addr = AW'(1);
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            if (scan_hit) begin
               seg_rd_en   = 1'b1;
               seg_rd_addr = chk_ff;
            end else if (!scan_last) begin
               bp_rd_en   = 1'b1;
               bp_rd_addr = chk_ff + AW'(2);
            end
         end
         ST_SEG: begin
            if (!seg_rd.valid && can_fall_back) begin
               seg_rd_en   = 1'b1;
               seg_rd_addr = seg_idx_ff - AW'(1);
            end
         end
         ST_ADD: begin
            if (act_ff == ACT_LOAD) begin
               seg_wr_en         = 1'b1;
               seg_wr_addr       = seg_addr_ff;
               seg_wr_data.valid = 1'b1;
               seg_wr_data.slope = slope_ff;
               seg_wr_data.icpt  = sum_sat;
            end
         end
         ST_PUSH: begin
            out_load = out_free;
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         last_x_ff     <= '0;
         last_y_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_START) begin
            if ((act_ff == ACT_LOAD) && !table_full) begin
               count_ff  <= count_ff + CW'(1);
               last_x_ff <= x_ff;
               last_y_ff <= y_ff;
            end else if (act_ff == ACT_CLEAR) begin
               count_ff  <= '0;
               last_x_ff <= '0;
               last_y_ff <= '0;
            end
         end
         if (out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // payload registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         act_ff <= req_tuser;
         x_ff   <= req_tdata[31:0];
         y_ff   <= req_tdata[63:32];
         q_ff   <= req_tdata[95:64];
      end

      case (state_ff)
         ST_START: begin
            res_value_ff <= '0;
            if ((act_ff == ACT_LOAD) && table_full) begin
               res_status_ff <= STAT_FULL;
            end else if ((act_ff == ACT_QUERY) && too_few) begin
               res_status_ff <= STAT_FEW;
            end else begin
               res_status_ff <= STAT_OK;
            end
            seg_addr_ff <= AW'(count_ff - CW'(1));
            neg_ff      <= dx[DIFF_W-1] ^ dy[DIFF_W-1];
            fallback_ff <= 1'b0;
            chk_ff      <= '0;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               slope_ff <= slope_sat;
            end
         end
         ST_SCAN: begin
            if (scan_hit) begin
               seg_idx_ff <= chk_ff;
            end else begin
               chk_ff <= chk_ff + AW'(1);
            end
         end
         ST_SEG: begin
            if (seg_rd.valid) begin
               slope_ff <= seg_rd.slope;
               icpt_ff  <= seg_rd.icpt;
            end else if (can_fall_back) begin
               // zero-width segment: use the one just before it
               fallback_ff <= 1'b1;
               seg_idx_ff  <= seg_idx_ff - AW'(1);
            end
         end
         ST_MUL: begin
            prod_ff <= slope_ff * mul_b;
         end
         ST_ADD: begin
            if (act_ff == ACT_QUERY) begin
               res_value_ff <= sum_sat;
            end
         end
         default: begin
         end
      endcase

      if (out_load) begin
         rsp_tdata_ff <= res_value_ff;
         rsp_tuser_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("breakpoint count beyond table depth");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second beat taken while an item is in work");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CW'(chk_ff) + CW'(2) <= count_ff))
      else $error("scan ran past the last stored segment");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != STAT_OK)) |-> (rsp_tdata == '0))
      else $error("nonzero value with an error status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STAT_OK || rsp_tuser == STAT_FULL ||
                      rsp_tuser == STAT_FEW))
      else $error("undefined status code");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import pli_pkg::*;

   localparam int DEPTH = 256;
   localparam int FRAC  = 24;
   localparam int ONE   = 1 << FRAC;            // 1.0 in Q7.24
   localparam logic [1:0] ACT_UNUSED = 2'd3;    // decoded as a no-op by the block

   // request beat as it travels on req_tdata / req_tuser
   typedef struct {
      logic [1:0]        op;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] qx;
   } interp_req_type;

   // response beat as it travels on rsp_tdata / rsp_tuser
   typedef struct {
      logic signed [31:0] value;
      logic [1:0]         status;
   } interp_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;     // [31:0] point_x, [63:32] point_y, [95:64] query_point
   logic [1:0]  req_tuser = '0;     // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [31:0] value
   logic [1:0]  rsp_tuser;          // [1:0] status

   piecewise_linear_interpolator #(
      .TABLE_DEPTH (DEPTH),
      .FRAC_BITS   (FRAC)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Shadow copy of the breakpoint table and the segment records
   // ------------------------------------------------------------------
   logic signed [31:0] bp_mem    [DEPTH];
   logic signed [31:0] slope_mem [DEPTH];
   logic signed [31:0] icpt_mem  [DEPTH];
   bit                 seg_ok    [DEPTH];
   int unsigned        n_points = 0;
   logic signed [31:0] prev_x = '0;
   logic signed [31:0] prev_y = '0;

   interp_req_type pending_q[$];    // beats waiting for the driver
   interp_rsp_type expected_q[$];   // predicted responses, oldest first

   int  errors   = 0;
   int  acc_cnt  = 0;               // request beats accepted so far
   int  total    = 0;               // request beats generated
   bit  req_fired = 1'b0;           // request handshake seen at the last rising edge
   bit  hold_rx   = 1'b0;           // long receiver hold-off
   int  n_load = 0, n_full = 0, n_query = 0, n_few = 0, n_zero = 0, n_clear = 0, n_noop = 0;

   // clamp a wide signed value to 32 bits
   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > longint'(SAT_MAX)) return SAT_MAX;
      if (v < longint'(SAT_MIN)) return SAT_MIN;
      return v[31:0];
   endfunction

   // (dy << F) / dx truncated toward zero, saturated to 32 bits
   function automatic logic signed [31:0] div_slope(input longint dy, input longint dx);
      bit                 neg;
      longint unsigned    num;
      longint unsigned    den;
      longint unsigned    quo;
      logic signed [31:0] r;
      neg = (dy < 0) != (dx < 0);
      num = (dy < 0) ? -dy : dy;
      num = num << FRAC;
      den = (dx < 0) ? -dx : dx;
      quo = num / den;
      if (neg) begin
         if (quo > 64'd2147483648) return SAT_MIN;
         r = quo[31:0];
         return -r;
      end
      if (quo > 64'd2147483647) return SAT_MAX;
      return quo[31:0];
   endfunction

   // intercept + floor(slope * q / 2^F) for one stored segment
   function automatic logic signed [31:0] seg_value(input int unsigned s,
                                                    input logic signed [31:0] q);
      longint p;
      p = longint'(slope_mem[s]) * longint'(q);
      return clamp32(longint'(icpt_mem[s]) + (p >>> FRAC));
   endfunction

   // apply one accepted beat to the shadow table and return the response it yields
   task automatic apply_to_table(input interp_req_type b, output interp_rsp_type r);
      int unsigned        seg;
      int unsigned        i;
      int unsigned        nseg;
      longint             dx;
      longint             dy;
      logic signed [31:0] m;
      r.value  = '0;
      r.status = STAT_OK;
      case (b.op)
         ACT_LOAD: begin
            if (n_points >= DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               bp_mem[n_points] = b.px;
               if (n_points >= 1) begin
                  seg = n_points - 1;
                  dx  = longint'(b.px) - longint'(prev_x);
                  dy  = longint'(b.py) - longint'(prev_y);
                  if (dx == 0) begin
                     // zero-width segment: stored as unusable
                     seg_ok[seg]    = 1'b0;
                     slope_mem[seg] = '0;
                     icpt_mem[seg]  = '0;
                  end else begin
                     m              = div_slope(dy, dx);
                     slope_mem[seg] = m;
                     icpt_mem[seg]  = clamp32(longint'(b.py) -
                                              ((longint'(m) * longint'(b.px)) >>> FRAC));
                     seg_ok[seg]    = 1'b1;
                  end
               end
               prev_x   = b.px;
               prev_y   = b.py;
               n_points = n_points + 1;
            end
         end
         ACT_QUERY: begin
            if (n_points < 2) begin
               r.status = STAT_FEW;
            end else begin
               nseg = n_points - 1;
               i    = 0;
               // first segment whose right breakpoint lies above the point
               while (i < nseg && !(b.qx < bp_mem[i+1])) i++;
               if (i < nseg) begin
                  if (seg_ok[i]) begin
                     r.value = seg_value(i, b.qx);
                  end else if (i > 0 && seg_ok[i-1]) begin
                     r.value = seg_value(i - 1, b.qx);
                  end
               end
            end
         end
         ACT_CLEAR: begin
            n_points = 0;
            prev_x   = '0;
            prev_y   = '0;
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------
   task automatic push_beat(input logic [1:0] op, input logic signed [31:0] px,
                            input logic signed [31:0] py, input logic signed [31:0] qx);
      interp_req_type b;
      b.op = op;
      b.px = px;
      b.py = py;
      b.qx = qx;
      pending_q.push_back(b);
   endtask

   task automatic push_load(input logic signed [31:0] px, input logic signed [31:0] py);
      push_beat(ACT_LOAD, px, py, $urandom);
   endtask

   task automatic push_query(input logic signed [31:0] qx);
      push_beat(ACT_QUERY, $urandom, $urandom, qx);
   endtask

   task automatic push_op(input logic [1:0] op);
      push_beat(op, $urandom, $urandom, $urandom);
   endtask

   // value within +-8.0, where results mostly stay unsaturated
   function automatic int near_val();
      return int'($urandom_range(32'h1000_0000)) - 32'h0800_0000;
   endfunction

   // one table build: optional clear, n ascending breakpoints, a few queries
   task automatic build_table_seq(input int n, input bit wide, input bit fresh);
      int xs[$];
      int v;
      int k;
      int j;
      int mode;
      if (fresh) push_op(ACT_CLEAR);
      for (int i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(9) == 0) begin
            v = xs[$urandom_range(xs.size() - 1)];      // repeated abscissa
         end else begin
            v = wide ? int'($urandom) : near_val();
         end
         j = 0;
         while (j < xs.size() && xs[j] <= v) j++;
         xs.insert(j, v);
      end
      foreach (xs[i]) push_load(xs[i], wide ? int'($urandom) : near_val());
      repeat ($urandom_range(1, 8)) begin
         mode = $urandom_range(3);
         if (n == 0 || mode == 0) begin
            push_query($urandom);
         end else if (mode == 3) begin
            push_query(near_val());
         end else begin
            k = $urandom_range(n - 1);
            push_query(xs[k] + ((mode == 1) ? int'($urandom_range(4)) - 2 : 0));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Idling: phase follows the accepted-beat count and cycles through
   // free-running, sender gaps, receiver stalls and both together
   // ------------------------------------------------------------------
   function automatic int idle_phase();
      return (acc_cnt / 150) % 4;
   endfunction

   function automatic bit sender_gap();
      case (idle_phase())
         1:       return $urandom_range(99) < 81;
         3:       return $urandom_range(99) < 33;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stall();
      case (idle_phase())
         2:       return $urandom_range(99) < 81;
         3:       return $urandom_range(99) < 33;
         default: return 1'b0;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Driver: request side changes on the falling edge only
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      interp_req_type b;
      if (!reset) begin
         if (!req_tvalid || req_fired) begin
            if (pending_q.size() > 0 && !sender_gap()) begin
               b          = pending_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {b.qx, b.py, b.px};
               req_tuser  <= b.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= !hold_rx && !receiver_stall();
      end
   end

   // ------------------------------------------------------------------
   // Monitor: both handshakes sampled on the rising edge. The response
   // check runs first, since a response never belongs to a request
   // accepted on the same edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      interp_req_type b;
      interp_rsp_type want;
      req_fired <= req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $display("%0t ERROR unexpected response beat: value %0d status %0d",
                        $time, $signed(rsp_tdata), rsp_tuser);
               errors++;
            end else begin
               want = expected_q.pop_front();
               if ($signed(rsp_tdata) !== want.value) begin
                  $display("%0t ERROR value: expected %0d actual %0d",
                           $time, want.value, $signed(rsp_tdata));
                  errors++;
               end
               if (rsp_tuser !== want.status) begin
                  $display("%0t ERROR status: expected %0d actual %0d",
                           $time, want.status, rsp_tuser);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            b.px = req_tdata[31:0];
            b.py = req_tdata[63:32];
            b.qx = req_tdata[95:64];
            b.op = req_tuser;
            apply_to_table(b, want);
            expected_q.push_back(want);
            acc_cnt++;
            case (b.op)
               ACT_LOAD:  if (want.status == STAT_FULL) n_full++; else n_load++;
               ACT_QUERY: begin
                  if (want.status == STAT_FEW) n_few++;
                  else if (want.value == 0) n_zero++;
                  else n_query++;
               end
               ACT_CLEAR: n_clear++;
               default:   n_noop++;
            endcase
         end
      end
   end

   // long receiver hold-off while the sender keeps offering beats
   initial begin
      wait (acc_cnt >= 300);
      @(posedge clock);
      hold_rx = 1'b1;
      repeat (3000) @(posedge clock);
      hold_rx = 1'b0;
   end

   // watchdog
   initial begin
      #30_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int directed;
      int r;
      // directed: empty table, single point, unused action
      push_query(32'sd0);
      push_load(32'sd0, 32'sd0);
      push_query(32'sd0);
      push_beat(ACT_UNUSED, -32'sd1, -32'sd1, -32'sd1);
      push_op(ACT_CLEAR);
      // table with a zero-width first segment, a saturating slope, a
      // negative slope, a repeated abscissa and a backward last point
      push_load(-32'sd1073741824, SAT_MAX);
      push_load(-32'sd1073741824, SAT_MIN);
      push_query(SAT_MIN);                      // lands on the unusable first segment
      push_load(-32'sd1073741823, SAT_MAX);     // dy huge, dx 1: slope clamps
      push_load(ONE, SAT_MIN);
      push_load(ONE, 32'sd0);
      push_load(SAT_MAX, SAT_MAX);
      push_load(SAT_MIN, 32'sd0);
      push_query(SAT_MIN);
      push_query(-32'sd1073741824);
      push_query(32'sd0);
      push_query(ONE);
      push_query(SAT_MAX);                      // past every right breakpoint
      // unit slope: midpoint, extrapolation below, exactly at the last point
      push_op(ACT_CLEAR);
      push_load(32'sd0, 32'sd0);
      push_load(ONE, ONE);
      push_query(ONE / 2);
      push_query(-32'sd1);
      push_query(ONE);
      directed = pending_q.size();

      // fill the table past its depth once, then query it
      push_op(ACT_CLEAR);
      for (int i = 0; i < DEPTH + 2; i++) begin
         push_load(32'(-64'sd2147483648 + longint'(i) * 64'sd8000000), $urandom);
      end
      repeat (6) push_query($urandom);
      push_query(SAT_MAX);

      // random: mostly well-formed builds, some noise on top of them
      while (pending_q.size() - directed < 1000) begin
         r = $urandom_range(99);
         if (r < 12) begin
            repeat ($urandom_range(1, 4)) begin
               push_beat($urandom_range(3), $urandom, $urandom, $urandom);
            end
         end else begin
            build_table_seq((r < 17) ? $urandom_range(1) : $urandom_range(2, 12),
                            $urandom_range(1), $urandom_range(5) != 0);
         end
      end
      total = pending_q.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (acc_cnt < total) @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);      // catch any stray response beat

      $display("covered %0d request beats: %0d loads, %0d rejected on a full table, %0d clears,",
               acc_cnt, n_load, n_full, n_clear);
      $display("  %0d nonzero queries, %0d zero-valued, %0d with too few points, %0d no-ops",
               n_query, n_zero, n_few, n_noop);
      if (errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

>>> piecewise_linear_interpolator.f
hdl/pli_pkg.sv
hdl/pli_ram.sv
hdl/pli_divider.sv
hdl/piecewise_linear_interpolator.sv
tb/tb_top.sv
